>>> rtl/iee_pkg.sv
package iee_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_expression;
    } iee_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } iee_out_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIV0      = 2'd1,
        ST_BADCHAR   = 2'd2,
        ST_MALFORMED = 2'd3
    } iee_status_t;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_LPAREN = 3'd4
    } iee_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHAR,
        S_RED_RD,
        S_RED_WAIT,
        S_RED_EXEC,
        S_DIV,
        S_RED_WB,
        S_END,
        S_OUT
    } iee_state_t;

    // Kind of character seen by the controller.
    typedef enum logic [2:0] {
        K_DIGIT,
        K_SPACE,
        K_LPAREN,
        K_RPAREN,
        K_OPER,
        K_BAD
    } iee_kind_t;

    // Why a reduction sequence is running.
    typedef enum logic [1:0] {
        R_OPER,
        R_RPAREN,
        R_END
    } iee_mode_t;

    typedef struct packed {
        logic       load_in;
        logic       digit;
        logic       flush;
        logic       push_op;
        logic       pop_op;
        logic       red_read;
        logic       red_exec;
        logic       div_step;
        logic       red_write;
        logic       set_err;
        iee_status_t err_code;
        logic       out_load;
        logic       clear;
    } iee_cmd_t;

    typedef struct packed {
        iee_kind_t  kind;
        logic       end_flag;
        logic       err;
        logic       num_busy;
        logic       op_empty;
        logic       top_lparen;
        logic       top_ge;
        logic       red_ok;
        logic       op_is_div;
        logic       div_zero;
        logic       div_done;
        logic       one_value;
    } iee_sts_t;

    function automatic logic is_high_prec(input logic [2:0] code);
        return (code == OP_MUL) || (code == OP_DIV);
    endfunction

endpackage

>>> rtl/iee_datapath.sv
module iee_datapath
    import iee_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  iee_in_t  in_item,
    input  iee_cmd_t cmd,
    output iee_sts_t sts,
    output iee_out_t out_item
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DCW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] vmem [STACK_DEPTH];
    logic [2:0]             omem [STACK_DEPTH];

    logic [7:0]             char_reg;
    logic                   end_reg;
    logic [CW-1:0]          vcnt_reg, vcnt_next;
    logic [CW-1:0]          ocnt_reg, ocnt_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   nip_reg, nip_next;
    iee_status_t            err_reg, err_next;
    logic [2:0]             otop_reg;
    logic [VALUE_WIDTH-1:0] va_reg, vb_reg, res_reg, res_next;
    logic [VALUE_WIDTH-1:0] top_val_reg;
    logic [2:0]             code_reg;
    logic [2:0]             opcode;
    logic [DCW-1:0]         dcnt_reg, dcnt_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next, quo_reg, quo_next, dvs_reg, dvs_next;
    logic                   qneg_reg, qneg_next;
    iee_out_t               out_reg;

    logic                   v_wr;
    logic [AW-1:0]          v_waddr;
    logic [VALUE_WIDTH-1:0] v_wdata;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] ma, mb;
    logic [2*VALUE_WIDTH-1:0] prod;

    always_comb begin
        case (char_reg)
            8'h2b:   opcode = OP_ADD;
            8'h2d:   opcode = OP_SUB;
            8'h2a:   opcode = OP_MUL;
            default: opcode = OP_DIV;
        endcase
    end

    always_comb begin
        if (char_reg >= 8'h30 && char_reg <= 8'h39) begin
            sts.kind = K_DIGIT;
        end else if (char_reg == 8'h20 || (char_reg >= 8'h09 && char_reg <= 8'h0d)) begin
            sts.kind = K_SPACE;
        end else if (char_reg == 8'h28) begin
            sts.kind = K_LPAREN;
        end else if (char_reg == 8'h29) begin
            sts.kind = K_RPAREN;
        end else if (char_reg == 8'h2b || char_reg == 8'h2d || char_reg == 8'h2a
                     || char_reg == 8'h2f) begin
            sts.kind = K_OPER;
        end else begin
            sts.kind = K_BAD;
        end
        sts.end_flag   = end_reg;
        sts.err        = (err_reg != ST_OK);
        sts.num_busy   = nip_reg;
        sts.op_empty   = (ocnt_reg == '0);
        sts.top_lparen = (otop_reg == OP_LPAREN);
        sts.top_ge     = is_high_prec(otop_reg) || !is_high_prec(opcode);
        sts.red_ok     = (ocnt_reg != '0) && (vcnt_reg >= CW'(2));
        sts.op_is_div  = (code_reg == OP_DIV);
        sts.div_zero   = (mb == '0);
        sts.div_done   = (dcnt_reg == '0);
        sts.one_value  = (vcnt_reg == CW'(1));
    end

    assign ma   = va_reg[VALUE_WIDTH-1] ? (~va_reg + 1'b1) : va_reg;
    assign mb   = vb_reg[VALUE_WIDTH-1] ? (~vb_reg + 1'b1) : vb_reg;
    assign prod = va_reg * vb_reg;
    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]} - {1'b0, dvs_reg};

    always_comb begin
        vcnt_next = vcnt_reg;
        ocnt_next = ocnt_reg;
        acc_next  = acc_reg;
        nip_next  = nip_reg;
        err_next  = err_reg;
        res_next  = res_reg;
        dcnt_next = dcnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        qneg_next = qneg_reg;
        v_wr      = 1'b0;
        v_waddr   = vcnt_reg[AW-1:0];
        v_wdata   = acc_reg;
        if (cmd.digit) begin
            acc_next = VALUE_WIDTH'(acc_reg * VALUE_WIDTH'(10)
                       + VALUE_WIDTH'(char_reg - 8'h30));
            nip_next = 1'b1;
        end
        if (cmd.flush) begin
            acc_next = '0;
            nip_next = 1'b0;
            if (vcnt_reg >= CW'(STACK_DEPTH)) begin
                if (err_reg == ST_OK) err_next = ST_MALFORMED;
            end else begin
                v_wr      = 1'b1;
                vcnt_next = vcnt_reg + 1'b1;
            end
        end
        if (cmd.push_op) begin
            if (ocnt_reg >= CW'(STACK_DEPTH)) begin
                if (err_reg == ST_OK) err_next = ST_MALFORMED;
            end else begin
                ocnt_next = ocnt_reg + 1'b1;
            end
        end
        if (cmd.pop_op) ocnt_next = ocnt_reg - 1'b1;
        if (cmd.red_read) begin
            ocnt_next = ocnt_reg - 1'b1;
            vcnt_next = vcnt_reg - CW'(2);
        end
        if (cmd.red_exec) begin
            case (code_reg)
                OP_SUB:  res_next = va_reg - vb_reg;
                OP_MUL:  res_next = prod[VALUE_WIDTH-1:0];
                default: res_next = va_reg + vb_reg;
            endcase
            rem_next  = '0;
            quo_next  = ma;
            dvs_next  = mb;
            qneg_next = va_reg[VALUE_WIDTH-1] ^ vb_reg[VALUE_WIDTH-1];
            dcnt_next = DCW'(VALUE_WIDTH);
        end
        if (cmd.div_step) begin
            if (!trial[VALUE_WIDTH]) begin
                rem_next = trial[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[VALUE_WIDTH-2:0], quo_reg[VALUE_WIDTH-1]};
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg - 1'b1;
            res_next  = qneg_reg ? (~quo_next + 1'b1) : quo_next;
        end
        if (cmd.red_write) begin
            v_wr      = 1'b1;
            v_wdata   = res_reg;
            vcnt_next = vcnt_reg + 1'b1;
        end
        if (cmd.set_err && err_reg == ST_OK) err_next = cmd.err_code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            vcnt_reg <= '0;
            ocnt_reg <= '0;
            acc_reg  <= '0;
            nip_reg  <= 1'b0;
            err_reg  <= ST_OK;
        end else begin
            vcnt_reg <= vcnt_next;
            ocnt_reg <= ocnt_next;
            acc_reg  <= acc_next;
            nip_reg  <= nip_next;
            err_reg  <= err_next;
        end
        dcnt_reg <= dcnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        res_reg  <= res_next;
        if (cmd.load_in) begin
            char_reg <= in_item.character;
            end_reg  <= in_item.end_of_expression;
        end
    end

    // Stack memories: one write port, reads registered. The top operator is
    // re-read every cycle from the next count.
    always_ff @(posedge aclk) begin
        if (v_wr) begin
            vmem[v_waddr] <= v_wdata;
            top_val_reg   <= v_wdata;
        end
        if (cmd.push_op && ocnt_reg < CW'(STACK_DEPTH)) begin
            omem[ocnt_reg[AW-1:0]] <= (sts.kind == K_LPAREN) ? OP_LPAREN : opcode;
        end
        otop_reg <= omem[AW'(ocnt_next - 1'b1)];
        if (cmd.red_read) begin
            code_reg <= otop_reg;
            vb_reg   <= vmem[AW'(vcnt_reg - 1'b1)];
            va_reg   <= vmem[AW'(vcnt_reg - CW'(2))];
        end
    end

    // When an expression ends well exactly one value is left, and it is always
    // the last one written, so the result is taken from a copy of that write.
    // The status includes an error raised in the same cycle.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.status       <= err_next;
            out_reg.result_value <= (err_next == ST_OK)
                                    ? 32'(signed'(top_val_reg)) : '0;
        end
    end
    assign out_item = out_reg;

endmodule

>>> rtl/iee_control.sv
module iee_control
    import iee_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  iee_sts_t sts,
    output iee_cmd_t cmd
);

    iee_state_t state_reg, state_next;
    iee_mode_t  mode_reg, mode_next;

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        case (state_reg)
            S_IDLE: if (s_valid) state_next = S_CHAR;
            S_CHAR: begin
                if (sts.end_flag) begin
                    state_next = S_END;
                end else if (sts.err || sts.kind == K_DIGIT || sts.kind == K_SPACE
                             || sts.kind == K_LPAREN || sts.kind == K_BAD
                             || sts.num_busy) begin
                    // a pending number is flushed first, then the character re-examined
                    state_next = (sts.num_busy && sts.kind != K_DIGIT && !sts.err)
                                 ? S_CHAR : S_IDLE;
                end else if (sts.kind == K_RPAREN) begin
                    mode_next  = R_RPAREN;
                    state_next = S_RED_RD;
                end else begin
                    mode_next  = R_OPER;
                    state_next = S_RED_RD;
                end
            end
            S_RED_RD: begin
                if (sts.err) begin
                    state_next = S_IDLE;
                end else if (sts.op_empty) begin
                    state_next = (mode_reg == R_END) ? S_OUT : S_IDLE;
                end else if (sts.top_lparen) begin
                    state_next = (mode_reg == R_END) ? S_OUT : S_IDLE;
                end else if (mode_reg == R_OPER && !sts.top_ge) begin
                    state_next = S_IDLE;
                end else if (!sts.red_ok) begin
                    state_next = (mode_reg == R_END) ? S_OUT : S_IDLE;
                end else begin
                    state_next = S_RED_WAIT;
                end
            end
            S_RED_WAIT: state_next = S_RED_EXEC;
            S_RED_EXEC: begin
                if (sts.op_is_div) begin
                    state_next = sts.div_zero ? ((mode_reg == R_END) ? S_OUT : S_IDLE)
                                              : S_DIV;
                end else begin
                    state_next = S_RED_WB;
                end
            end
            S_DIV: if (sts.div_done) state_next = S_RED_WB;
            S_RED_WB: state_next = S_RED_RD;
            S_END: begin
                mode_next  = R_END;
                state_next = (sts.err || !sts.num_busy) ? S_RED_RD : S_END;
                if (sts.err) state_next = S_OUT;
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.err_code = ST_OK;
        s_ready      = (state_reg == S_IDLE);
        m_valid      = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE: cmd.load_in = s_valid;
            S_CHAR: begin
                if (!sts.end_flag && !sts.err) begin
                    if (sts.kind == K_DIGIT) begin
                        cmd.digit = 1'b1;
                    end else if (sts.num_busy) begin
                        cmd.flush = 1'b1;
                    end else if (sts.kind == K_LPAREN) begin
                        cmd.push_op = 1'b1;
                    end else if (sts.kind == K_BAD) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_BADCHAR;
                    end
                end
            end
            S_RED_RD: begin
                if (!sts.err) begin
                    if (sts.op_empty) begin
                        if (mode_reg == R_OPER) begin
                            cmd.push_op = 1'b1;
                        end else if (mode_reg == R_RPAREN) begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ST_MALFORMED;
                        end else if (!sts.one_value) begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ST_MALFORMED;
                        end
                    end else if (sts.top_lparen) begin
                        if (mode_reg == R_OPER) begin
                            cmd.push_op = 1'b1;
                        end else if (mode_reg == R_RPAREN) begin
                            cmd.pop_op = 1'b1;
                        end else begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ST_MALFORMED;
                        end
                    end else if (mode_reg == R_OPER && !sts.top_ge) begin
                        cmd.push_op = 1'b1;
                    end else if (!sts.red_ok) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_MALFORMED;
                    end else begin
                        cmd.red_read = 1'b1;
                    end
                end
            end
            S_RED_EXEC: begin
                cmd.red_exec = 1'b1;
                if (sts.op_is_div && sts.div_zero) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_DIV0;
                end
            end
            S_DIV: cmd.div_step = !sts.div_done;
            S_RED_WB: cmd.red_write = 1'b1;
            S_END: cmd.flush = sts.num_busy && !sts.err;
            S_OUT: begin
                cmd.out_load = 1'b0;
                cmd.clear    = m_ready;
            end
            default: ;
        endcase
        if (state_next == S_OUT && state_reg != S_OUT) cmd.out_load = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= R_OPER;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("input taken while a result is pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped before transfer");
    a_clear_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> (m_valid && m_ready)) else $error("state cleared without transfer");

endmodule

>>> rtl/infix_expression_evaluator_top.sv
// Infix expression evaluator.
// Input channel s_: one ASCII character per transaction in s_data; an item
// with end_of_expression set finishes the expression. Output channel m_:
// one transaction per end item, carrying the 32-bit result and a status
// (ok, divide by zero, invalid character, malformed).
// Items are handled one at a time; s_ready is high only while the block
// waits for the next character. After a character is accepted it is
// examined in S_CHAR; an operator or ')' then passes through S_RED_RD,
// and a character that ends a number is examined again after the flush.
// Every reduction runs S_RED_RD, S_RED_WAIT, S_RED_EXEC and S_RED_WB, and a
// division adds S_DIV for its bit-serial divider, between S_RED_EXEC and
// S_RED_WB; the stack reads are registered and one reduction unit is shared.
// After an end item the block flushes a pending number in S_END and runs the
// same reductions before m_valid rises in S_OUT.
// After reset (aresetn low, synchronous) the stacks are empty and no error
// is held. While the receiver holds m_ready low the result stays on m_data
// and no further character is taken; the state clears when it is taken.
module infix_expression_evaluator_top
    import iee_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  iee_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output iee_out_t m_data
);

    iee_cmd_t cmd;
    iee_sts_t sts;

    iee_control u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    iee_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (m_data)
    );

endmodule

>>> bench/tb_infix_expression_evaluator_top.sv
module tb_infix_expression_evaluator_top;
    import iee_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    iee_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    iee_out_t m_data;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          items_sent = 0;
    string       op_chars = "+-*/";

    // Evaluator state mirrored by the testbench.
    logic [31:0] val_stk [DEPTH];
    iee_op_t     op_stk [DEPTH];
    int          val_cnt;
    int          op_cnt;
    logic [31:0] num_acc;
    logic        num_busy;
    iee_status_t err_state;

    iee_out_t    results_due [$];

    infix_expression_evaluator_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    task automatic clear_eval();
        val_cnt = 0;
        op_cnt = 0;
        num_acc = '0;
        num_busy = 1'b0;
        err_state = ST_OK;
    endtask

    task automatic flag_error(input iee_status_t code);
        if (err_state == ST_OK) err_state = code;
    endtask

    task automatic push_val(input logic [31:0] v);
        if (val_cnt >= DEPTH) flag_error(ST_MALFORMED);
        else begin
            val_stk[val_cnt] = v;
            val_cnt++;
        end
    endtask

    task automatic push_oper(input iee_op_t code);
        if (op_cnt >= DEPTH) flag_error(ST_MALFORMED);
        else begin
            op_stk[op_cnt] = code;
            op_cnt++;
        end
    endtask

    function automatic int op_rank(input iee_op_t code);
        return (code == OP_MUL || code == OP_DIV) ? 2 : 1;
    endfunction

    task automatic apply_top_op();
        iee_op_t     code;
        logic [31:0] a, b, r, ma, mb;
        if (op_cnt == 0 || val_cnt < 2) begin
            flag_error(ST_MALFORMED);
            return;
        end
        op_cnt--;
        code = op_stk[op_cnt];
        b = val_stk[val_cnt - 1];
        a = val_stk[val_cnt - 2];
        val_cnt -= 2;
        case (code)
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: begin
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                if (mb == 0) begin
                    flag_error(ST_DIV0);
                    return;
                end
                r = ma / mb;
                if (a[31] != b[31]) r = -r;
            end
            default: r = a + b;
        endcase
        val_stk[val_cnt] = r;
        val_cnt++;
    endtask

    task automatic flush_num();
        if (num_busy) begin
            push_val(num_acc);
            num_acc = '0;
            num_busy = 1'b0;
        end
    endtask

    task automatic eval_char(input logic [7:0] c);
        iee_op_t code;
        if (c >= "0" && c <= "9") begin
            num_acc = num_acc * 10 + 32'(c - "0");
            num_busy = 1'b1;
            return;
        end
        flush_num();
        if (err_state != ST_OK) return;
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
        if (c == "(") begin
            push_oper(OP_LPAREN);
            return;
        end
        if (c == ")") begin
            forever begin
                if (op_cnt == 0) begin
                    flag_error(ST_MALFORMED);
                    return;
                end
                if (op_stk[op_cnt - 1] == OP_LPAREN) break;
                apply_top_op();
                if (err_state != ST_OK) return;
            end
            op_cnt--;
            return;
        end
        case (c)
            "+": code = OP_ADD;
            "-": code = OP_SUB;
            "*": code = OP_MUL;
            "/": code = OP_DIV;
            default: begin
                flag_error(ST_BADCHAR);
                return;
            end
        endcase
        while (op_cnt != 0 && err_state == ST_OK) begin
            if (op_stk[op_cnt - 1] == OP_LPAREN ||
                op_rank(op_stk[op_cnt - 1]) < op_rank(code)) break;
            apply_top_op();
        end
        if (err_state == ST_OK) push_oper(code);
    endtask

    task automatic eval_item(input iee_in_t item);
        iee_out_t res;
        if (!item.end_of_expression) begin
            if (err_state == ST_OK) eval_char(item.character);
            return;
        end
        if (err_state == ST_OK) flush_num();
        while (err_state == ST_OK && op_cnt != 0) begin
            if (op_stk[op_cnt - 1] == OP_LPAREN) flag_error(ST_MALFORMED);
            else apply_top_op();
        end
        if (err_state == ST_OK && val_cnt != 1) flag_error(ST_MALFORMED);
        res.status = err_state;
        res.result_value = (err_state == ST_OK) ? val_stk[0] : '0;
        results_due.push_back(res);
        clear_eval();
    endtask

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Valid stays high after a transaction until the next one is driven, the
    // sender idles or the testbench waits for the results to drain.
    task automatic send_item(input iee_in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        items_sent++;
        eval_item(item);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_char(input logic [7:0] c);
        iee_in_t item;
        item.character = c;
        item.end_of_expression = 1'b0;
        send_item(item);
    endtask

    task automatic send_end();
        iee_in_t item;
        item.character = 8'($urandom);
        item.end_of_expression = 1'b1;
        send_item(item);
    endtask

    task automatic send_expr(input string text);
        foreach (text[i]) send_char(text[i]);
        send_end();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Result checking and receiver stalls.
    always @(posedge aclk) begin
        iee_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = results_due.pop_front();
                if (m_data.result_value !== want.result_value)
                    report_mismatch($sformatf("value %0d, expected %0d",
                        m_data.result_value, want.result_value));
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                        m_data.status, want.status));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 8'("0" + $urandom_range(9));
        if (r < 70) return op_chars[$urandom_range(3)];
        if (r < 90) return $urandom_range(1) ? "(" : ")";
        if (r < 96) return " ";
        return 8'($urandom);
    endfunction

    // A well-formed expression with random numbers, operators and nesting.
    task automatic send_random_expr(input int terms);
        int depth;
        int n;
        depth = 0;
        for (int t = 0; t < terms; t++) begin
            if (t > 0) send_char(op_chars[$urandom_range(3)]);
            if (depth < 4 && $urandom_range(3) == 0) begin
                send_char("(");
                depth++;
            end
            n = $urandom_range(1, 4);
            for (int d = 0; d < n; d++) send_char(8'("0" + $urandom_range(9)));
            if ($urandom_range(7) == 0) send_char(" ");
            if (depth > 0 && $urandom_range(2) == 0) begin
                send_char(")");
                depth--;
            end
        end
        while (depth > 0) begin
            send_char(")");
            depth--;
        end
        send_end();
    endtask

    task automatic test_directed();
        send_expr("1+2*3");
        send_expr("(1+2)*3");
        send_expr("10-4-3");
        send_expr("100/7/2");
        send_expr("-7");
        send_expr("0-7/2");
        send_expr("8/(3-3)");
        send_expr("2147483647+1");
        send_expr("4294967295");
        send_expr("(0-2147483647-1)/(0-1)");
        send_expr(" \t1\n+\r2\013*\0143 ");
        send_expr("1+a");
        send_char(8'hFF);
        send_end();
        send_expr("(1+2");
        send_expr("1+2)");
        send_expr("");
        send_expr("1 2");
        send_expr("()");
        send_expr("99999999999");
        wait_drained();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < DEPTH + 2; i++) send_char("(");
        send_char("1");
        send_end();
        for (int i = 0; i < DEPTH + 1; i++) begin
            send_char("1");
            send_char(" ");
        end
        send_end();
        wait_drained();
    endtask

    task automatic test_random(input int items);
        int start;
        int noise;
        start = items_sent;
        while (items_sent - start < items) begin
            if ($urandom_range(4) != 0) begin
                send_random_expr($urandom_range(1, 6));
            end else begin
                noise = $urandom_range(1, 10);
                for (int i = 0; i < noise; i++) send_char(pick_char());
                send_end();
            end
        end
    endtask

    initial begin
        clear_eval();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        test_random(20);
        send_idle_pct = 66;
        test_random(20);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 66;
        test_random(20);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        test_random(20);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(20);
        wait_drained();
        repeat (100) @(posedge aclk);
        if (error_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
